### sv/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_WIDE  = 2'd1;
  localparam logic [1:0] ERR_LARGE = 2'd2;

  // header constants
  localparam logic [6:0]  LEN_CODE_16 = 7'd126;
  localparam logic [6:0]  LEN_CODE_64 = 7'd127;
  localparam logic [3:0]  EXT_BYTES_16 = 4'd2;
  localparam logic [3:0]  EXT_BYTES_64 = 4'd8;
  localparam logic [3:0]  EXT_LOW_BYTES = 4'd3;
  localparam logic [3:0]  KEY_BYTES = 4'd4;
  localparam logic [23:0] MAX_PAYLOAD_RST = 24'h100000;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  op_fin;
    logic [23:0] payload_len;
    logic [7:0]  data_byte;
    logic        last;
    logic [1:0]  error_code;
  } res_t;

endpackage

`default_nettype wire

### sv/websocket_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   in_byte[7:0]
// out_      output     out_valid / out_stall kind, op_fin, payload_len, data_byte,
//                                            last, error_code
// cfg_      input      cfg_we                cfg_wdata[23:0] (max_payload)
//
// one byte per cycle while out_stall is low; a result is valid on out_ once its
// byte has passed the input register, then the parser into the result register
// only the byte that completes a header, a payload byte or a length fault
// gives a result; other header, key and extended length bytes give none
// rst_n is synchronous; after reset max_payload is 0x100000 and the parser
// waits for a first header byte
// a stalled result holds the parser, and the input register then stalls in_

module websocket_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_op_fin,
  output logic [23:0]      out_payload_len,
  output logic [7:0]       out_data_byte,
  output logic             out_last,
  output logic [1:0]       out_error_code,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata
);

  import wsd_pkg::*;

  logic [23:0] max_r;
  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        free;
  logic        step;
  logic        res_valid;
  res_t        res;

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  // parser steps when the result slot can take whatever it produces
  assign step = byte_valid && free;

  wsd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .take       (step),
    .in_stall   (in_stall),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  wsd_parser u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .byte_in     (byte_q),
    .max_payload (max_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (res_valid),
    .res             (res),
    .out_stall       (out_stall),
    .free            (free),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_op_fin      (out_op_fin),
    .out_payload_len (out_payload_len),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .out_error_code  (out_error_code)
  );

endmodule

`default_nettype wire

### sv/wsd_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,
  output logic            in_stall,
  output logic            byte_valid,
  output logic [7:0]      byte_q
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // hold a request until the parser consumes it
  assign in_stall  = valid_r && !take;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

endmodule

`default_nettype wire

### sv/wsd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    byte_in,
  input  wire logic [23:0]   max_payload,
  output logic               res_valid,
  output wsd_pkg::res_t      res
);

  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        err_r, err_nxt;
  logic        mask_on_r, mask_on_nxt;
  logic [3:0]  ext_r, ext_nxt;
  logic [7:0]  frame_op_r, frame_op_nxt;
  logic [23:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [23:0] idx_r, idx_nxt;

  logic        do_done, do_hdr, do_err;
  logic [1:0]  err_code;
  logic [7:0]  key_byte;
  logic        is_last;

  // one byte of frame parsing
  always_comb begin
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    mask_on_nxt  = mask_on_r;
    ext_nxt      = ext_r;
    frame_op_nxt = frame_op_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    do_done      = 1'b0;
    do_hdr       = 1'b0;
    do_err       = 1'b0;
    err_code     = ERR_NONE;
    key_byte     = 8'd0;
    is_last      = 1'b0;
    res_valid    = 1'b0;
    res          = '{kind: KIND_HDR, op_fin: frame_op_r, payload_len: 24'd0,
                     data_byte: 8'd0, last: 1'b0, error_code: ERR_NONE};

    if (step && !err_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          frame_op_nxt = byte_in;
          phase_nxt    = PH_HDR1;
        end
        PH_HDR1: begin
          mask_on_nxt = byte_in[7];
          key_nxt     = 32'd0;
          len_nxt     = 24'd0;
          if (byte_in[6:0] == LEN_CODE_64) begin
            ext_nxt   = EXT_BYTES_64;
            phase_nxt = PH_EXT;
          end else if (byte_in[6:0] == LEN_CODE_16) begin
            ext_nxt   = EXT_BYTES_16;
            phase_nxt = PH_EXT;
          end else begin
            len_nxt = {17'd0, byte_in[6:0]};
            do_done = 1'b1;
          end
        end
        PH_EXT: begin
          if (ext_r > EXT_LOW_BYTES && byte_in != 8'd0) begin
            do_err   = 1'b1;
            err_code = ERR_WIDE;
          end else begin
            // upper bytes of a 64-bit length must be zero
            if (ext_r <= EXT_LOW_BYTES) begin
              len_nxt = {len_r[15:0], byte_in};
            end
            ext_nxt = ext_r - 4'd1;
            do_done = (ext_nxt == 4'd0);
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], byte_in};
          ext_nxt = ext_r - 4'd1;
          do_hdr  = (ext_nxt == 4'd0);
        end
        PH_DATA: begin
          // key byte picked by index modulo 4, first key byte at index 0
          if (mask_on_r) begin
            unique case (idx_r[1:0])
              2'd0: key_byte = key_r[31:24];
              2'd1: key_byte = key_r[23:16];
              2'd2: key_byte = key_r[15:8];
              2'd3: key_byte = key_r[7:0];
              default: key_byte = 8'd0;
            endcase
          end
          is_last   = ({1'b0, idx_r} + 25'd1) >= {1'b0, len_r};
          res_valid = 1'b1;
          res       = '{kind: KIND_DATA, op_fin: frame_op_r, payload_len: len_r,
                        data_byte: byte_in ^ key_byte, last: is_last,
                        error_code: ERR_NONE};
          idx_nxt   = idx_r + 24'd1;
          if (is_last) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // length complete: limit check, then key or header
      if (do_done) begin
        if (len_nxt > max_payload) begin
          do_err   = 1'b1;
          err_code = ERR_LARGE;
        end else if (mask_on_nxt) begin
          phase_nxt = PH_MASK;
          ext_nxt   = KEY_BYTES;
        end else begin
          do_hdr = 1'b1;
        end
      end

      // header result
      if (do_hdr) begin
        idx_nxt   = 24'd0;
        phase_nxt = (len_nxt == 24'd0) ? PH_HDR0 : PH_DATA;
        res_valid = 1'b1;
        res       = '{kind: KIND_HDR, op_fin: frame_op_r, payload_len: len_nxt,
                      data_byte: 8'd0, last: (len_nxt == 24'd0),
                      error_code: ERR_NONE};
      end

      // error result, then latch
      if (do_err) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_HDR0;
        res_valid = 1'b1;
        res       = '{kind: KIND_ERR, op_fin: frame_op_r, payload_len: 24'd0,
                      data_byte: 8'd0, last: 1'b1, error_code: err_code};
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      err_r     <= 1'b0;
      mask_on_r <= 1'b0;
      ext_r     <= 4'd0;
    end else begin
      phase_r   <= phase_nxt;
      err_r     <= err_nxt;
      mask_on_r <= mask_on_nxt;
      ext_r     <= ext_nxt;
    end
  end

  // frame fields
  always_ff @(posedge clk) begin
    frame_op_r <= frame_op_nxt;
    len_r      <= len_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
  end

endmodule

`default_nettype wire

### sv/wsd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire wsd_pkg::res_t res,
  input  wire logic          out_stall,
  output logic               free,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_op_fin,
  output logic [23:0]        out_payload_len,
  output logic [7:0]         out_data_byte,
  output logic               out_last,
  output logic [1:0]         out_error_code
);

  import wsd_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // slot is free when empty or being drained this cycle
  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (free ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = res_r.kind;
  assign out_op_fin      = res_r.op_fin;
  assign out_payload_len = res_r.payload_len;
  assign out_data_byte   = res_r.data_byte;
  assign out_last        = res_r.last;
  assign out_error_code  = res_r.error_code;

endmodule

`default_nettype wire
